// ===== sv/sst_pkg.sv =====
// Shared types and constants for the short string intern table.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sst_pkg;

    localparam int TEXT_BITS = 120;
    localparam int TEXT_BYTES = 15;
    localparam int LEN_BITS = 4;
    localparam int SLOT_FIELD_BITS = 15;
    localparam int HANDLE_BITS = 10;
    localparam int HASH_NIBBLES = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = 1;
    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    typedef enum logic [2:0] {
        OUT_EMPTY    = 3'd0,
        OUT_SINGLE   = 3'd1,
        OUT_FOUND    = 3'd2,
        OUT_INSERTED = 3'd3,
        OUT_FULL     = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        K_EMPTY,
        K_SINGLE,
        K_FULL,
        K_LOOKUP
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic [SLOT_FIELD_BITS-1:0]  slot;
        logic [TEXT_BITS-1:0]        text;
        logic [LEN_BITS-1:0]         len;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SLOT_RD,
        B_SLOT_CHK,
        B_ENT_CHK
    } t_back_state;

endpackage

// ===== sv/short_string_intern_table.sv =====
// Top level of the short string intern table: front, queue and back.
// Depends on sst_pkg, sst_front, sst_queue and sst_back.
//
// Input channel: i_valid / o_stall with the string bytes and length. A word
// is taken when i_valid is high and o_stall is low. Output channel: o_valid /
// i_stall with outcome, handle, ASCII flag and echoed length; a result word
// is taken when o_valid is high and i_stall is low.
// The front hashes one byte per cycle and then reduces the hash four bits per
// cycle to a slot index; the empty, single-byte and too-long cases skip both
// steps. A two-entry queue decouples it from the back, which takes a job only
// once its result register is empty, reads and checks a slot for each probe,
// compares the stored entry when the slot is in use, and then writes the
// result register; the trivial cases need no probe.
// After reset the back clears every slot of the slot table; the front
// still takes words and queues them meanwhile. When the receiver stalls, the
// result is held in the output register and the back waits, while the front
// and queue keep accepting until full.
module short_string_intern_table import sst_pkg::*; #(
    parameter int ENTRY_COUNT = 1024,
    parameter int SLOT_COUNT  = 2048,
    parameter int MAX_LENGTH  = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [63:0]            i_text_low,
    input  logic [55:0]            i_text_high,
    input  logic [LEN_BITS-1:0]    i_text_length,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_outcome,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_is_ascii,
    output logic [LEN_BITS-1:0]    o_result_length
);

    logic push_valid;
    t_job push_job;
    logic q_full;
    logic pop_valid;
    t_job pop_job;
    logic pop;

    sst_front #(
        .SLOT_COUNT (SLOT_COUNT),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_low    (i_text_low),
        .i_text_high   (i_text_high),
        .i_text_length (i_text_length),
        .o_job_valid   (push_valid),
        .o_job         (push_job),
        .i_job_full    (q_full)
    );

    sst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_full       (q_full),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop        (pop)
    );

    sst_back #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (pop_valid),
        .i_job           (pop_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_outcome       (o_outcome),
        .o_handle        (o_handle),
        .o_is_ascii      (o_is_ascii),
        .o_result_length (o_result_length)
    );

endmodule

// ===== sv/sst_front.sv =====
// Front end: accepts a string word, classifies it, hashes it with FNV-1a
// one byte per cycle and reduces the hash to a slot index. Uses sst_pkg.
module sst_front import sst_pkg::*; #(
    parameter int SLOT_COUNT = 2048,
    parameter int MAX_LENGTH = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [63:0]         i_text_low,
    input  logic [55:0]         i_text_high,
    input  logic [LEN_BITS-1:0] i_text_length,
    output logic                o_job_valid,
    output t_job                o_job,
    input  logic                i_job_full
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [SW:0] S_MOD = (SW+1)'(SLOT_COUNT);

    t_front_state         r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [TEXT_BITS-1:0] r_text, n_text;
    logic [TEXT_BITS-1:0] r_shift, n_shift;
    logic [LEN_BITS-1:0]  r_len, n_len;
    logic [LEN_BITS-1:0]  r_left, n_left;
    logic [31:0]          r_hash, n_hash;
    logic [SW-1:0]        r_rem, n_rem;
    logic [2:0]           r_nib, n_nib;

    logic [TEXT_BITS-1:0] raw;
    logic [TEXT_BITS-1:0] text_in;
    logic [31:0]          hash_x;
    logic [31:0]          prod;
    logic [SW-1:0]        rem_v;
    logic [SW:0]          t;

    assign raw = {i_text_high, i_text_low};
    assign hash_x = r_hash ^ {24'h000000, r_shift[7:0]};
    assign prod = hash_x * FNV_PRIME;

    always_comb begin
        for (int b = 0; b < TEXT_BYTES; b++) begin
            text_in[b*8 +: 8] = (LEN_BITS'(b) < i_text_length) ? raw[b*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        rem_v = r_rem;
        t = '0;
        for (int k = 0; k < 4; k++) begin
            t = {rem_v, r_hash[31-k]};
            if (t >= S_MOD) begin
                t = t - S_MOD;
            end
            rem_v = t[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_text  <= n_text;
        r_shift <= n_shift;
        r_len   <= n_len;
        r_left  <= n_left;
        r_hash  <= n_hash;
        r_rem   <= n_rem;
        r_nib   <= n_nib;
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_text  = r_text;
        n_shift = r_shift;
        n_len   = r_len;
        n_left  = r_left;
        n_hash  = r_hash;
        n_rem   = r_rem;
        n_nib   = r_nib;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_text  = text_in;
                    n_shift = text_in;
                    n_len   = i_text_length;
                    n_left  = i_text_length - 1'b1;
                    n_hash  = FNV_BASIS;
                    n_rem   = '0;
                    n_nib   = '0;
                    if (i_text_length == '0) begin
                        n_kind  = K_EMPTY;
                        n_state = F_PUSH;
                    end else if (i_text_length == LEN_BITS'(1)) begin
                        n_kind  = K_SINGLE;
                        n_state = F_PUSH;
                    end else if (i_text_length > LEN_BITS'(MAX_LENGTH)) begin
                        n_kind  = K_FULL;
                        n_state = F_PUSH;
                    end else begin
                        n_kind  = K_LOOKUP;
                        n_state = F_HASH;
                    end
                end
            end
            F_HASH: begin
                n_hash  = prod;
                n_shift = r_shift >> 8;
                if (r_left == '0) begin
                    n_state = F_MOD;
                end else begin
                    n_left = r_left - 1'b1;
                end
            end
            F_MOD: begin
                n_rem  = rem_v;
                n_hash = r_hash << 4;
                n_nib  = r_nib + 1'b1;
                if (r_nib == 3'(HASH_NIBBLES - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job.kind = r_kind;
    assign o_job.slot = SLOT_FIELD_BITS'(r_rem);
    assign o_job.text = r_text;
    assign o_job.len = r_len;

endmodule

// ===== sv/sst_queue.sv =====
// Two-entry queue that carries classified jobs from the front to the back.
// Uses the job type from sst_pkg.
module sst_queue import sst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_full,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wp, n_wp;
    logic [QPTR_BITS-1:0] r_rp, n_rp;
    logic [QPTR_BITS:0]   r_cnt, n_cnt;
    logic                 push;
    logic                 pop;

    assign o_full = (r_cnt == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_job = r_mem[r_rp];
    assign push = i_push_valid && !o_full;
    assign pop = i_pop && o_pop_valid;

    always_comb begin
        n_wp = push ? r_wp + 1'b1 : r_wp;
        n_rp = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

// ===== sv/sst_back.sv =====
// Back end: probes the slot table, compares stored entries, inserts new ones
// and holds the result register. Holds the slot and entry memories; uses sst_pkg.
module sst_back import sst_pkg::*; #(
    parameter int ENTRY_COUNT = 1024,
    parameter int SLOT_COUNT  = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_outcome,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_is_ascii,
    output logic [LEN_BITS-1:0]    o_result_length
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $clog2(ENTRY_COUNT);
    localparam int UW = $clog2(ENTRY_COUNT + 1);
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam logic [SW:0] S_MOD = (SW+1)'(SLOT_COUNT);

    function automatic logic [HANDLE_BITS-1:0] to_handle(input logic [31:0] v);
        return v[HANDLE_BITS-1:0];
    endfunction

    logic [UW-1:0]        slot_mem [SLOT_COUNT];
    logic [TEXT_BITS:0]   ent_mem [ENTRY_COUNT];

    t_back_state          r_state, n_state;
    logic [SW-1:0]        r_clr, n_clr;
    t_job                 r_job, n_job;
    logic [SW-1:0]        r_slot, n_slot;
    logic [PW-1:0]        r_probes, n_probes;
    logic [UW-1:0]        r_used, n_used;
    logic [UW-1:0]        r_tag;
    logic [TEXT_BITS:0]   r_ent;
    logic                 r_out_valid, n_out_valid;
    t_outcome             r_outcome, n_outcome;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic                 r_ascii, n_ascii;
    logic [LEN_BITS-1:0]  r_len, n_len;

    logic                 slot_we;
    logic [SW-1:0]        slot_wa;
    logic [UW-1:0]        slot_wd;
    logic                 ent_we;
    logic [UW-1:0]        tag_m1;
    logic                 match;
    logic                 ascii_new;
    logic [SW:0]          sum;

    assign tag_m1 = r_tag - 1'b1;

    always_comb begin
        match = 1'b1;
        ascii_new = 1'b1;
        for (int b = 0; b < TEXT_BYTES; b++) begin
            if (LEN_BITS'(b) <= r_job.len) begin
                if (r_ent[b*8 +: 8] != r_job.text[b*8 +: 8]) begin
                    match = 1'b0;
                end
            end
            if (r_job.text[b*8 + 7]) begin
                ascii_new = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_tag <= slot_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[r_used[EW-1:0]] <= {ascii_new, r_job.text};
        end
        r_ent <= ent_mem[tag_m1[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_slot    <= n_slot;
        r_probes  <= n_probes;
        r_outcome <= n_outcome;
        r_handle  <= n_handle;
        r_ascii   <= n_ascii;
        r_len     <= n_len;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_job       = r_job;
        n_slot      = r_slot;
        n_probes    = r_probes;
        n_used      = r_used;
        n_out_valid = r_out_valid && i_stall;
        n_outcome   = r_outcome;
        n_handle    = r_handle;
        n_ascii     = r_ascii;
        n_len       = r_len;
        slot_we     = 1'b0;
        slot_wa     = r_slot;
        slot_wd     = '0;
        ent_we      = 1'b0;
        o_pop       = 1'b0;
        sum         = '0;
        case (r_state)
            B_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == SW'(SLOT_COUNT - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid && !r_out_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_len = i_job.len;
                    case (i_job.kind)
                        K_EMPTY: begin
                            n_out_valid = 1'b1;
                            n_outcome   = OUT_EMPTY;
                            n_handle    = '0;
                            n_ascii     = 1'b1;
                        end
                        K_SINGLE: begin
                            n_out_valid = 1'b1;
                            n_outcome   = OUT_SINGLE;
                            n_handle    = HANDLE_BITS'(i_job.text[7:0]);
                            n_ascii     = !i_job.text[7];
                        end
                        K_FULL: begin
                            n_out_valid = 1'b1;
                            n_outcome   = OUT_FULL;
                            n_handle    = '0;
                            n_ascii     = 1'b0;
                        end
                        default: begin
                            n_slot   = i_job.slot[SW-1:0];
                            n_probes = '0;
                            n_state  = B_SLOT_RD;
                        end
                    endcase
                end
            end
            B_SLOT_RD: begin
                n_state = B_SLOT_CHK;
            end
            B_SLOT_CHK: begin
                if (r_tag == '0) begin
                    n_state     = B_IDLE;
                    n_out_valid = 1'b1;
                    if (r_used >= UW'(ENTRY_COUNT)) begin
                        n_outcome = OUT_FULL;
                        n_handle  = '0;
                        n_ascii   = 1'b0;
                    end else begin
                        slot_we   = 1'b1;
                        slot_wd   = r_used + 1'b1;
                        ent_we    = 1'b1;
                        n_used    = r_used + 1'b1;
                        n_outcome = OUT_INSERTED;
                        n_handle  = to_handle(32'(r_used));
                        n_ascii   = ascii_new;
                    end
                end else begin
                    n_state = B_ENT_CHK;
                end
            end
            B_ENT_CHK: begin
                if (match) begin
                    n_state     = B_IDLE;
                    n_out_valid = 1'b1;
                    n_outcome   = OUT_FOUND;
                    n_handle    = to_handle(32'(tag_m1));
                    n_ascii     = r_ent[TEXT_BITS];
                end else begin
                    n_probes = r_probes + 1'b1;
                    if (n_probes == PW'(SLOT_COUNT)) begin
                        n_state     = B_IDLE;
                        n_out_valid = 1'b1;
                        n_outcome   = OUT_FULL;
                        n_handle    = '0;
                        n_ascii     = 1'b0;
                    end else begin
                        sum = {1'b0, r_slot} + (SW+1)'(n_probes);
                        if (sum >= S_MOD) begin
                            sum = sum - S_MOD;
                        end
                        n_slot  = sum[SW-1:0];
                        n_state = B_SLOT_RD;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_outcome = r_outcome;
    assign o_handle = r_handle;
    assign o_is_ascii = r_ascii;
    assign o_result_length = r_len;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(ENTRY_COUNT))
        else $error("entry count exceeds pool size");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop)
        else $error("job taken during clearing pass");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SLOT_CHK && r_tag == '0 && r_used < UW'(ENTRY_COUNT))
        |=> (r_used == $past(r_used) + 1'b1) && r_out_valid)
        else $error("insert did not allocate an entry");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SLOT_RD) |-> (r_probes < PW'(SLOT_COUNT)))
        else $error("probe count out of range");

endmodule

// ===== test/short_string_intern_table_check.sv =====
// Checker for the short string intern table: watches both channels, predicts
// each result from its own copy of the table and compares. Depends on sst_pkg.
`timescale 1ns / 100ps
module short_string_intern_table_check import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_o_stall,
    input  logic [63:0] i_text_low,
    input  logic [55:0] i_text_high,
    input  logic [3:0]  i_text_length,
    input  logic        i_o_valid,
    input  logic        i_stall,
    input  logic [2:0]  i_outcome,
    input  logic [9:0]  i_handle,
    input  logic        i_is_ascii,
    input  logic [3:0]  i_result_length,
    output int          o_errors,
    output int          o_pending
);

    localparam int ENTRIES = 1024;
    localparam int SLOTS = 2048;

    typedef struct packed {
        t_outcome   outcome;
        logic [9:0] handle;
        logic       ascii;
        logic [3:0] len;
    } t_answer;

    logic [10:0]  slot_tags [SLOTS];
    logic [119:0] entry_text [ENTRIES];
    logic         entry_flag [ENTRIES];
    int           used_entries;
    t_answer      awaited [$];

    initial begin
        o_errors = 0;
        o_pending = 0;
        for (int k = 0; k < SLOTS; k++) slot_tags[k] = '0;
        used_entries = 0;
    end

    function automatic t_answer intern_lookup(logic [63:0] lo, logic [55:0] hi,
                                              logic [3:0] n);
        logic [119:0] txt;
        logic [31:0]  hash;
        int           slot;
        int           step;
        int           idx;
        logic [7:0]   nxt;
        logic [7:0]   orb;
        t_answer      ans;
        txt = {hi, lo};
        for (int k = 0; k < 15; k++) if (k >= n) txt[8*k +: 8] = 8'h00;
        ans = '{OUT_FULL, 10'd0, 1'b0, n};
        if (n == 0) return '{OUT_EMPTY, 10'd0, 1'b1, n};
        if (n == 1) return '{OUT_SINGLE, {2'b0, txt[7:0]}, ~txt[7], n};
        hash = FNV_BASIS;
        for (int k = 0; k < n; k++) hash = (hash ^ {24'd0, txt[8*k +: 8]}) * FNV_PRIME;
        slot = hash % SLOTS;
        step = 1;
        for (int p = 0; p < SLOTS; p++) begin
            if (slot_tags[slot] == 0) begin
                if (used_entries >= ENTRIES) return ans;
                idx = used_entries;
                used_entries++;
                orb = 0;
                for (int k = 0; k < 15; k++) orb |= txt[8*k +: 8];
                entry_text[idx] = txt;
                entry_flag[idx] = ~orb[7];
                slot_tags[slot] = 11'(idx + 1);
                return '{OUT_INSERTED, idx[9:0], entry_flag[idx], n};
            end
            idx = slot_tags[slot] - 1;
            nxt = (n < 15) ? entry_text[idx][8*n +: 8] : 8'h00;
            if (nxt == 0 && (entry_text[idx] & ((120'd1 << (8*n)) - 120'd1)) == txt)
                return '{OUT_FOUND, idx[9:0], entry_flag[idx], n};
            slot = (slot + step) % SLOTS;
            step++;
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && i_valid && !i_o_stall)
            awaited.push_back(intern_lookup(i_text_low, i_text_high, i_text_length));
        if (i_rst_n && i_o_valid && !i_stall) begin
            if (awaited.size() == 0) begin
                report_mismatch("unexpected word", i_outcome, 0);
            end else begin
                want = awaited.pop_front();
                if (i_outcome != want.outcome) report_mismatch("outcome", i_outcome, want.outcome);
                if (i_handle != want.handle) report_mismatch("handle", i_handle, want.handle);
                if (i_is_ascii != want.ascii) report_mismatch("is_ascii", i_is_ascii, want.ascii);
                if (i_result_length != want.len)
                    report_mismatch("result_length", i_result_length, want.len);
            end
        end
        o_pending = awaited.size();
    end

endmodule

// ===== test/short_string_intern_table_test.sv =====
// Top of the short string intern table testbench: clock, reset, stimulus and
// verdict. Depends on sst_pkg, the block and short_string_intern_table_check.
`timescale 1ns / 100ps
module short_string_intern_table_test;
    import sst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_text_low = '0;
    logic [55:0] i_text_high = '0;
    logic [3:0]  i_text_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_outcome;
    logic [9:0]  o_handle;
    logic        o_is_ascii;
    logic [3:0]  o_result_length;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    logic [119:0] vocab [64];

    always #4 i_clk = ~i_clk;

    short_string_intern_table dut (.*);

    short_string_intern_table_check checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_o_stall(o_stall), .i_text_low, .i_text_high,
        .i_text_length, .i_o_valid(o_valid), .i_stall, .i_outcome(o_outcome),
        .i_handle(o_handle), .i_is_ascii(o_is_ascii), .i_result_length(o_result_length),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        int burst;
        if (!calm && $urandom_range(0, 20) == 0) begin
            burst = $urandom_range(1, 17);
            i_stall <= 1'b1;
            repeat (burst) @(posedge i_clk);
        end
        i_stall <= 1'b0;
    end

    task automatic send_word(logic [119:0] txt, logic [3:0] n);
        if (!calm && $urandom_range(0, 12) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        for (int k = 0; k < 15; k++) if (k >= n) txt[8*k +: 8] = 8'h00;
        i_valid <= 1'b1;
        i_text_low <= txt[63:0];
        i_text_high <= txt[119:64];
        i_text_length <= n;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [119:0] random_text();
        return 120'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    initial begin
        logic [119:0] t;
        int           pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_word('0, 4'd0);
        send_word({15{8'hFF}}, 4'd0);
        send_word(120'h7F, 4'd1);
        send_word(120'hFF, 4'd1);
        send_word(120'h00, 4'd1);
        send_word({15{8'hFF}}, 4'd15);
        send_word({15{8'hFF}}, 4'd15);
        send_word({15{8'h41}}, 4'd15);
        send_word(120'h4241, 4'd2);
        send_word(120'h4241, 4'd3);
        send_word(120'h4241, 4'd4);
        send_word(120'h4241, 4'd2);
        send_word(120'h0000, 4'd2);
        send_word(120'h8041, 4'd2);
        send_word({15{8'h55}}, 4'd9);
        send_word({15{8'hAA}}, 4'd14);
        for (int k = 0; k < 64; k++) vocab[k] = random_text();
        for (int k = 0; k < 1500; k++) begin
            if (k > 1300) calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                t = vocab[$urandom_range(0, 63)];
                send_word(t, 4'($urandom_range(2, 8)));
            end else if (pick < 7) begin
                t = random_text();
                if ($urandom_range(0, 1)) t = t & {15{8'h7F}};
                send_word(t, 4'($urandom_range(2, 15)));
            end else begin
                send_word(random_text(), 4'($urandom_range(0, 15)));
            end
        end
        // Fill the pool until it is exhausted, then send twenty more random words and one vocabulary word.
        while (checker_inst.used_entries < 1024) send_word(random_text(), 4'd15);
        for (int k = 0; k < 20; k++) send_word(random_text(), 4'($urandom_range(2, 15)));
        send_word(vocab[0], 4'd5);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sst_pkg.sv
sv/sst_front.sv
sv/sst_queue.sv
sv/sst_back.sv
sv/short_string_intern_table.sv
test/short_string_intern_table_check.sv
test/short_string_intern_table_test.sv
